### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked checks that are dropped when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true out of reset
`define SHA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the sha-256 hasher
// round constants, initial hash value, block layout and core control types
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam hash_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       init;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
    } core_stat_t;

endpackage

### rtl/sha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_if: valid/ready channels of the sha-256 hasher
// message byte channel in, digest word channel out
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_present,
                    output message_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input message_end, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

### rtl/sha256_hasher.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sha256_hasher: byte-stream sha-256 with built-in padding
// one message byte per word in, eight digest words out at message end
// ----------------------------------------------------------------------------
// a byte word is taken while ready is high; the 64th byte of a block starts
// compression (64 rounds of the shared round unit, one fold, one handback)
// at message end padding enters one byte per cycle outside compression (1 to 64
// pad bytes per block), each padded block is compressed, then 8 digest words follow
// no new byte is taken until a block's compression ends; ready is low while busy
// reset (async, active low) restores the initial hash value and zero length
module sha256_hasher
(
    input  logic         clk,
    input  logic         rst_n,
    sha_in_if.sink       msg,
    sha_out_if.source    digest
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_PAD  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [60:0]         count_reg, count_next;
    logic [5:0]          pos_reg, pos_next;
    logic                mark_reg, mark_next;
    logic                len_reg, len_next;
    logic [2:0]          idx_reg, idx_next;

    sha_pkg::core_ctrl_t ctrl;
    sha_pkg::core_stat_t stat;
    sha_pkg::hash_t      hv;

    logic                accept;
    logic                out_take;
    logic [63:0]         bit_len;
    logic                len_now;
    logic [7:0]          len_byte;
    logic [7:0]          pad_byte;

    sha_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .hv    (hv)
    );

    assign msg.ready          = (state_reg == S_IDLE);
    assign accept             = msg.valid && msg.ready;
    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_word = hv[idx_reg];
    assign digest.digest_last = (idx_reg == sha_pkg::LAST_WORD);
    assign out_take           = digest.valid && digest.ready;

    // padding byte: marker, zero fill, then the bit length big-endian
    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = bit_len[{~pos_reg[2:0], 3'b000} +: 8];
    assign len_now  = len_reg || (!mark_reg && pos_reg == sha_pkg::LEN_POS);
    assign pad_byte = mark_reg ? sha_pkg::PAD_BYTE : (len_now ? len_byte : 8'h00);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mark_next = msg.message_end;
                    if (msg.message_end)
                    begin
                        state_next = S_PAD;
                    end
                    if (msg.byte_present)
                    begin
                        ctrl.shift_en   = 1'b1;
                        ctrl.shift_byte = msg.data_byte;
                        count_next      = count_reg + 61'd1;
                        pos_next        = pos_reg + 6'd1;
                        if (pos_reg == sha_pkg::LAST_POS)
                        begin
                            ctrl.start = 1'b1;
                            state_next = S_HASH;
                            ret_next   = msg.message_end ? S_PAD : S_IDLE;
                        end
                    end
                end
            end
            S_HASH:
            begin
                if (!stat.busy)
                begin
                    state_next = ret_reg;
                end
            end
            S_PAD:
            begin
                ctrl.shift_en   = 1'b1;
                ctrl.shift_byte = pad_byte;
                pos_next        = pos_reg + 6'd1;
                mark_next       = 1'b0;
                if (len_now)
                begin
                    len_next = 1'b1;
                end
                if (pos_reg == sha_pkg::LAST_POS)
                begin
                    ctrl.start = 1'b1;
                    state_next = S_HASH;
                    ret_next   = len_now ? S_OUT : S_PAD;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::LAST_WORD)
                    begin
                        ctrl.init  = 1'b1;
                        count_next = '0;
                        pos_next   = '0;
                        len_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    `SHA_ASSERT_NEVER(a_in_out_excl, clk, rst_n, msg.ready && digest.valid, "input ready while digest pending")
    `SHA_ASSERT(a_start_full, clk, rst_n, ctrl.start |-> (ctrl.shift_en && pos_reg == sha_pkg::LAST_POS), "compression started on a partial block")
    `SHA_ASSERT(a_last_resets, clk, rst_n, (out_take && idx_reg == sha_pkg::LAST_WORD) |=> (state_reg == S_IDLE && count_reg == 61'd0 && pos_reg == 6'd0), "no return to idle after digest")
    `SHA_ASSERT(a_out_idle_core, clk, rst_n, digest.valid |-> !stat.busy, "digest shown during compression")

endmodule

### rtl/sha_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sha_core: iterative sha-256 compression engine
// 16-word schedule window loaded a byte at a time, one round per cycle,
// then a fold step into the chaining value (once per block)
// ----------------------------------------------------------------------------
module sha_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::core_ctrl_t ctrl,
    output sha_pkg::core_stat_t stat,
    output sha_pkg::hash_t      hv
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FOLD  = 3'b100
    } core_state_t;

    function automatic sha_pkg::word_t rotr(input sha_pkg::word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    core_state_t     state_reg, state_next;
    logic [5:0]      round_reg, round_next;
    sha_pkg::word_t  w_reg [16];
    sha_pkg::word_t  v_reg [8];
    sha_pkg::hash_t  hv_reg;

    sha_pkg::word_t  s0, s1, w_new, sum1, sum0, ch, maj, t1, t2;

    assign stat.busy = (state_reg != C_IDLE);
    assign hv        = hv_reg;

    // message schedule and round arithmetic
    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        sum1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        sum0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + sum1 + ch + sha_pkg::ROUND_K[round_reg] + w_reg[0];
        t2    = sum0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = C_ROUND;
                    round_next = '0;
                end
            end
            C_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == sha_pkg::LAST_ROUND)
                begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // schedule window: byte shift while loading, word shift while running
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_reg[15] <= {w_reg[15][23:0], ctrl.shift_byte};
        end
        else if (state_reg == C_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    // working variables a..h
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hv_reg[i];
            end
        end
        else if (state_reg == C_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= sha_pkg::INIT_H;
        end
        else if (ctrl.init)
        begin
            hv_reg <= sha_pkg::INIT_H;
        end
        else if (state_reg == C_FOLD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= hv_reg[i] + v_reg[i];
            end
        end
    end

    `SHA_ASSERT(a_start_idle, clk, rst_n, ctrl.start |-> (state_reg == C_IDLE), "start while busy")
    `SHA_ASSERT(a_start_busy, clk, rst_n, ctrl.start |=> stat.busy, "start did not raise busy")
    `SHA_ASSERT(a_fold_after_last, clk, rst_n, (state_reg == C_ROUND && round_reg == sha_pkg::LAST_ROUND) |=> (state_reg == C_FOLD), "no fold after last round")
    `SHA_ASSERT_NEVER(a_init_busy, clk, rst_n, ctrl.init && stat.busy, "chaining reset while busy")

endmodule
